>>> rtl/core/aeg_pkg.sv
// Shared types, constants and table builders for the expander gain stage.
package aeg_pkg;

   localparam int ACC_W      = 64;   // serial multiplier accumulator
   localparam int MP_W       = 32;   // serial multiplier operand that is shifted out
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int GAIN_W     = 16;
   localparam int DEN_W      = 28;   // ratio times knee
   localparam int QUO_W      = 18;   // 17 quotient bits plus overflow bit
   localparam int COEF_W     = 24;

   localparam logic [COEF_W:0] COEF_ONE   = 25'h100_0000;
   localparam logic [18:0]     DB_PER_OCT = 19'd394566;  // 20*log10(2) in Q16
   localparam logic [13:0]     OCT_PER_DB = 14'd10885;   // log2(10)/20 in Q16
   localparam int              FLOOR_DB   = 120;
   localparam logic [14:0]     RATIO_ONE  = 15'd256;
   localparam logic [63:0]     Q30_ONE    = 64'h4000_0000;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RATIO     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KNEE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MODE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_AUTO_GAIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ATTACK    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE   = 3'd6;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ENV,
      S_NORM,
      S_LVL,
      S_CURVE,
      S_MUL1,
      S_MUL2,
      S_DIVCHK,
      S_DIV,
      S_SAT,
      S_TRACK,
      S_EMUL,
      S_AUTO,
      S_EXP,
      S_OMUL,
      S_RND,
      S_OUT
   } state_type;

   // log2 of a Q1.30 mantissa in [1,2), Q0.16, by repeated squaring
   function automatic logic [15:0] log2q16(input logic [63:0] mant);
      logic [63:0] m;
      logic [15:0] r;
      m = mant;
      r = '0;
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 30;
         r = {r[14:0], 1'b0};
         if (m >= (Q30_ONE << 1)) begin
            r[0] = 1'b1;
            m    = m >> 1;
         end
      end
      return r;
   endfunction

   // smallest Q1.30 mantissa whose log2 reaches target
   function automatic logic [30:0] exp_search(input logic [15:0] target);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lo = Q30_ONE;
      hi = (Q30_ONE << 1) - 64'd1;
      for (int k = 0; k < 32; k++) begin
         if (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (log2q16(mid) >= target) hi = mid;
            else lo = mid + 64'd1;
         end
      end
      return lo[30:0];
   endfunction

endpackage

>>> rtl/core/audio_expander_gain.sv
// Downward expander / compressor gain stage with soft knee, bit-serial datapath.
// One word in flight; its processing time is set by one shared shift-add multiplier that
// retires one multiplier bit per cycle (stops early once the multiplier is exhausted), a
// restoring divider and an envelope normalizer that shifts one bit per cycle. A new word
// is accepted only after the previous one has been loaded into the output register, so it
// waits longer while the previous result still sits unread there; a finished word waits
// there while the next is accepted. Reset: synchronous, active high; clears the control
// registers to their defaults, envelope and frame minimum to zero.
module audio_expander_gain #(
   parameter int SAMPLE_BITS     = 24,
   parameter int DB_FRAC_BITS    = 8,
   parameter int LOG_TABLE_DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   input  logic                                  req_frame_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample_out,
   output logic signed [aeg_pkg::GAIN_W-1:0]     rsp_gain_db,
   output logic                                  rsp_frame_last,
   output logic signed [aeg_pkg::GAIN_W-1:0]     rsp_frame_min_gain,
   input  logic                                  csr_we,
   input  logic [aeg_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [aeg_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import aeg_pkg::*;

   localparam int SB    = SAMPLE_BITS;
   localparam int IDX_W = $clog2(LOG_TABLE_DEPTH);
   localparam int SH_W  = $clog2(SAMPLE_BITS);
   localparam int NL_W  = SH_W + 16;
   localparam int LV_W  = DB_FRAC_BITS + 10;
   localparam int CW    = ((LV_W > 16) ? LV_W : 16) + 3;
   localparam int LP_W  = SB - 1 + IDX_W;
   localparam int FP_W  = 16 + IDX_W;

   // ---------------------------------------------------------------
   // Log2 and exp2 tables, built at elaboration
   // ---------------------------------------------------------------
   logic [15:0] log_rom [LOG_TABLE_DEPTH];
   logic [30:0] exp_rom [LOG_TABLE_DEPTH];

   for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++) begin : g_rom
      localparam logic [63:0] MANT =
         ((64'(LOG_TABLE_DEPTH) + 64'(gi)) << 30) / 64'(LOG_TABLE_DEPTH);
      localparam logic [63:0] TGT  = (64'(gi) << 16) / 64'(LOG_TABLE_DEPTH);
      localparam logic [15:0] LOG_V = log2q16(MANT);
      localparam logic [30:0] EXP_V = exp_search(TGT[15:0]);
      assign log_rom[gi] = LOG_V;
      assign exp_rom[gi] = EXP_V;
   end

   // ---------------------------------------------------------------
   // Control/status registers
   // ---------------------------------------------------------------
   logic signed [15:0] thr_ff;
   logic [14:0]        ratio_ff;
   logic [12:0]        knee_ff;
   logic               mode_ff;
   logic               auto_ff;
   logic [COEF_W-1:0]  atk_ff;
   logic [COEF_W-1:0]  rel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= -16'sd10240;
         ratio_ff <= 15'd512;
         knee_ff  <= '0;
         mode_ff  <= 1'b0;
         auto_ff  <= 1'b0;
         atk_ff   <= 24'd16000000;
         rel_ff   <= 24'd16700000;
      end else if (csr_we) begin
         case (csr_index)
            REG_THRESHOLD: thr_ff   <= csr_wdata[15:0];
            REG_RATIO:     ratio_ff <= csr_wdata[14:0];
            REG_KNEE:      knee_ff  <= csr_wdata[12:0];
            REG_MODE:      mode_ff  <= csr_wdata[0];
            REG_AUTO_GAIN: auto_ff  <= csr_wdata[0];
            REG_ATTACK:    atk_ff   <= csr_wdata;
            REG_RELEASE:   rel_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // State
   // ---------------------------------------------------------------
   state_type state_ff, state_in;

   logic [SB-1:0]            env_ff, env_in;
   logic signed [GAIN_W-1:0] trk_ff, trk_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // item payload
   logic [SB-1:0]            ax_ff, ax_in;
   logic                     sign_ff, sign_in;
   logic                     fend_ff, fend_in;

   // shared shift-add multiplier
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [ACC_W-1:0]         mca_ff, mca_in;
   logic [ACC_W-1:0]         mcb_ff, mcb_in;
   logic [MP_W-1:0]          mpa_ff, mpa_in;
   logic [MP_W-1:0]          mpb_ff, mpb_in;

   // normalizer, level, curve
   logic [SB-1:0]            nrm_ff, nrm_in;
   logic [SH_W-1:0]          shc_ff, shc_in;
   logic signed [LV_W-1:0]   lvl_ff, lvl_in;
   logic                     kn_ff, kn_in;
   logic                     neg_ff, neg_in;
   logic [CW-1:0]            tf_ff, tf_in;
   logic [DEN_W-1:0]         den_ff, den_in;

   // divider
   logic [ACC_W-1:0]         rem_ff, rem_in;
   logic [ACC_W-1:0]         dsh_ff, dsh_in;
   logic [QUO_W-1:0]         q_ff, q_in;
   logic [4:0]               cnt_ff, cnt_in;

   // gain path
   logic signed [GAIN_W-1:0] g_ff, g_in;
   logic signed [31:0]       e_ff, e_in;
   logic [5:0]               s_ff, s_in;

   // output register
   logic signed [SB-1:0]     o_sample_ff, o_sample_in;
   logic signed [GAIN_W-1:0] o_gain_ff, o_gain_in;
   logic                     o_last_ff, o_last_in;
   logic signed [GAIN_W-1:0] o_min_ff, o_min_in;

   // ---------------------------------------------------------------
   // Shared combinational terms
   // ---------------------------------------------------------------
   logic              mac_done;
   logic              out_load;
   logic [SB-1:0]     env_new;
   logic [SB-1:0]     ax_new;
   logic [COEF_W-1:0] c_sel;
   logic [LP_W-1:0]   lprod;
   logic [IDX_W-1:0]  lidx;
   logic [NL_W-1:0]   nl2;
   logic [LV_W-1:0]   lmag;

   assign mac_done = (mpa_ff == '0) && (mpb_ff == '0);
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
   assign env_new  = acc_ff[COEF_W +: SB];
   assign ax_new   = req_sample_in[SB-1] ? (~req_sample_in + 1'b1) : req_sample_in;
   assign c_sel    = (ax_new > env_ff) ? atk_ff : rel_ff;
   assign lprod    = LP_W'(nrm_ff[SB-2:0]) * LP_W'(LOG_TABLE_DEPTH);
   assign lidx     = lprod[LP_W-1:SB-1];
   assign nl2      = NL_W'({shc_ff, 16'h0000}) - NL_W'(log_rom[lidx]);
   assign lmag     = LV_W'(acc_ff >> (32 - DB_FRAC_BITS));

   // static curve terms
   logic [14:0]          r_eff;
   logic [DEN_W-1:0]     r_knee;
   logic signed [CW-1:0] lvl_x, thr_x, knee_x, half_x, tlow, thigh, dval;
   logic                 curve_zero, curve_knee;
   logic [CW-1:0]        tf_val, d_mag;
   logic [DEN_W-1:0]     den_val;

   always_comb begin
      r_eff      = (ratio_ff < RATIO_ONE) ? RATIO_ONE : ratio_ff;
      r_knee     = DEN_W'(r_eff) * DEN_W'(knee_ff);
      lvl_x      = CW'(lvl_ff);
      thr_x      = CW'(thr_ff);
      knee_x     = $signed(CW'(knee_ff));
      half_x     = $signed(CW'(knee_ff >> 1));
      tlow       = thr_x - half_x;
      thigh      = tlow + knee_x;
      dval       = lvl_x - thr_x;
      d_mag      = dval[CW-1] ? CW'(-dval) : CW'(dval);
      curve_zero = 1'b1;
      curve_knee = 1'b0;
      tf_val     = '0;
      den_val    = DEN_W'(RATIO_ONE);
      if (!mode_ff) begin
         if (lvl_x < tlow) begin
            curve_zero = 1'b0;
         end else if ((lvl_x < thigh) && (knee_ff != '0)) begin
            curve_zero = 1'b0;
            curve_knee = 1'b1;
            tf_val     = CW'(thigh - lvl_x);
            den_val    = DEN_W'({knee_ff, 8'h00});
         end
      end else begin
         if (lvl_x > thigh) begin
            curve_zero = 1'b0;
            den_val    = DEN_W'(r_eff);
         end else if ((lvl_x > tlow) && (knee_ff != '0)) begin
            curve_zero = 1'b0;
            curve_knee = 1'b1;
            tf_val     = CW'(lvl_x - tlow);
            den_val    = r_knee;
         end
      end
   end

   // gain-to-linear terms
   logic [GAIN_W-1:0]    g_mag;
   logic [31:0]          pm;
   logic signed [31:0]   ps, ne, comp;
   logic signed [15:0]   n_val;
   logic signed [16:0]   sraw;
   logic [FP_W-1:0]      fprod;
   logic [IDX_W-1:0]     eidx;
   logic [ACC_W-1:0]     lim, qs;

   always_comb begin
      g_mag = g_ff[GAIN_W-1] ? GAIN_W'(-g_ff) : GAIN_W'(g_ff);
      pm    = acc_ff[31:0];
      ps    = g_ff[GAIN_W-1] ? -$signed(pm) : $signed(pm);
      ne    = -e_ff;
      comp  = ne >>> 1;
      if (comp > 32'sd65536) comp = 32'sd65536;
      n_val = e_ff[31:16];
      sraw  = 17'sd30 - 17'(n_val);
      fprod = FP_W'(e_ff[15:0]) * FP_W'(LOG_TABLE_DEPTH);
      eidx  = fprod[FP_W-1:16];
      lim   = ACC_W'(1) << (SB - 1);
      if (sign_ff) qs = (rem_ff > lim) ? lim : rem_ff;
      else         qs = (rem_ff > (lim - 1'b1)) ? (lim - 1'b1) : rem_ff;
   end

   // ---------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_ENV;
         S_ENV:    if (mac_done) state_in = (env_new == '0) ? S_CURVE : S_NORM;
         S_NORM:   if (nrm_ff[SB-1]) state_in = (shc_ff == '0) ? S_CURVE : S_LVL;
         S_LVL:    if (mac_done) state_in = S_CURVE;
         S_CURVE:  state_in = curve_zero ? S_TRACK : S_MUL1;
         S_MUL1:   if (mac_done) state_in = kn_ff ? S_MUL2 : S_DIVCHK;
         S_MUL2:   if (mac_done) state_in = S_DIVCHK;
         S_DIVCHK: state_in = S_DIV;
         S_DIV:    if (cnt_ff == '0) state_in = S_SAT;
         S_SAT:    state_in = S_TRACK;
         S_TRACK:  state_in = S_EMUL;
         S_EMUL:   if (mac_done) state_in = S_AUTO;
         S_AUTO:   state_in = S_EXP;
         S_EXP:    state_in = S_OMUL;
         S_OMUL:   if (mac_done) state_in = S_RND;
         S_RND:    state_in = S_OUT;
         S_OUT:    if (out_load) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // Datapath and outputs
   // ---------------------------------------------------------------
   always_comb begin
      env_in       = env_ff;
      trk_in       = trk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ax_in        = ax_ff;
      sign_in      = sign_ff;
      fend_in      = fend_ff;
      acc_in       = acc_ff;
      mca_in       = mca_ff;
      mcb_in       = mcb_ff;
      mpa_in       = mpa_ff;
      mpb_in       = mpb_ff;
      nrm_in       = nrm_ff;
      shc_in       = shc_ff;
      lvl_in       = lvl_ff;
      kn_in        = kn_ff;
      neg_in       = neg_ff;
      tf_in        = tf_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      g_in         = g_ff;
      e_in         = e_ff;
      s_in         = s_ff;
      o_sample_in  = o_sample_ff;
      o_gain_in    = o_gain_ff;
      o_last_in    = o_last_ff;
      o_min_in     = o_min_ff;

      // one multiplier bit per cycle, LSB first
      if (state_ff inside {S_ENV, S_LVL, S_MUL1, S_MUL2, S_EMUL, S_OMUL}) begin
         acc_in = acc_ff + (mpa_ff[0] ? mca_ff : '0) + (mpb_ff[0] ? mcb_ff : '0);
         mca_in = mca_ff << 1;
         mcb_in = mcb_ff << 1;
         mpa_in = mpa_ff >> 1;
         mpb_in = mpb_ff >> 1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ax_in   = ax_new;
               sign_in = req_sample_in[SB-1];
               fend_in = req_frame_end;
               // env' = c*env + (1-c)*|x|, rounded
               acc_in  = ACC_W'(COEF_ONE >> 1);
               mca_in  = ACC_W'(env_ff);
               mcb_in  = ACC_W'(ax_new);
               mpa_in  = MP_W'(c_sel);
               mpb_in  = MP_W'(COEF_ONE - {1'b0, c_sel});
            end
         end
         S_ENV: begin
            if (mac_done) begin
               env_in = env_new;
               nrm_in = env_new;
               shc_in = '0;
               lvl_in = -LV_W'(FLOOR_DB << DB_FRAC_BITS);
            end
         end
         S_NORM: begin
            if (nrm_ff[SB-1]) begin
               if (shc_ff == '0) begin
                  lvl_in = '0;
               end else begin
                  acc_in = ACC_W'(64'd1 << (31 - DB_FRAC_BITS));
                  mca_in = ACC_W'(DB_PER_OCT);
                  mcb_in = '0;
                  mpa_in = MP_W'(nl2);
                  mpb_in = '0;
               end
            end else begin
               nrm_in = nrm_ff << 1;
               shc_in = shc_ff + 1'b1;
            end
         end
         S_LVL: begin
            if (mac_done) lvl_in = LV_W'(-lmag);
         end
         S_CURVE: begin
            if (curve_zero) begin
               g_in = '0;
            end else begin
               kn_in  = curve_knee;
               neg_in = dval[CW-1] ^ mode_ff;
               tf_in  = tf_val;
               den_in = den_val;
               acc_in = '0;
               mca_in = ACC_W'(d_mag);
               mcb_in = '0;
               mpa_in = MP_W'(r_eff - RATIO_ONE);
               mpb_in = '0;
            end
         end
         S_MUL1: begin
            if (mac_done && kn_ff) begin
               acc_in = '0;
               mca_in = acc_ff;
               mpa_in = MP_W'(tf_ff);
               mpb_in = '0;
            end
         end
         S_DIVCHK: begin
            // round to nearest: (num + den/2) / den
            rem_in = acc_ff + ACC_W'(den_ff >> 1);
            dsh_in = ACC_W'(den_ff) << (QUO_W - 1);
            q_in   = '0;
            cnt_in = 5'(QUO_W - 1);
         end
         S_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               q_in   = {q_ff[QUO_W-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[QUO_W-2:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
         end
         S_SAT: begin
            if (neg_ff) g_in = (q_ff > QUO_W'(32768)) ? 16'sh8000 : GAIN_W'(~q_ff + 1'b1);
            else        g_in = (q_ff > QUO_W'(32767)) ? 16'sh7FFF : GAIN_W'(q_ff);
         end
         S_TRACK: begin
            if (g_ff < trk_ff) trk_in = g_ff;
            acc_in = '0;
            mca_in = ACC_W'(OCT_PER_DB);
            mcb_in = '0;
            mpa_in = MP_W'(g_mag);
            mpb_in = '0;
         end
         S_EMUL: begin
            if (mac_done) e_in = ps >>> DB_FRAC_BITS;
         end
         S_AUTO: begin
            if (auto_ff) e_in = e_ff + comp;
         end
         S_EXP: begin
            if (sraw < 17'sd1)       s_in = 6'd1;
            else if (sraw > 17'sd63) s_in = 6'd63;
            else                     s_in = sraw[5:0];
            acc_in = '0;
            mca_in = ACC_W'(exp_rom[eidx]);
            mcb_in = '0;
            mpa_in = MP_W'(ax_ff);
            mpb_in = '0;
         end
         S_RND: begin
            rem_in = (acc_ff + (ACC_W'(1) << (s_ff - 6'd1))) >> s_ff;
         end
         S_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               o_sample_in  = sign_ff ? SB'(~qs + 1'b1) : SB'(qs);
               o_gain_in    = g_ff;
               o_last_in    = fend_ff;
               o_min_in     = fend_ff ? trk_ff : '0;
               if (fend_ff) trk_in = '0;
            end
         end
         default: ;
      endcase
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_out     = o_sample_ff;
   assign rsp_gain_db        = o_gain_ff;
   assign rsp_frame_last     = o_last_ff;
   assign rsp_frame_min_gain = o_min_ff;

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         env_ff       <= '0;
         trk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         env_ff       <= env_in;
         trk_ff       <= trk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff       <= ax_in;
      sign_ff     <= sign_in;
      fend_ff     <= fend_in;
      acc_ff      <= acc_in;
      mca_ff      <= mca_in;
      mcb_ff      <= mcb_in;
      mpa_ff      <= mpa_in;
      mpb_ff      <= mpb_in;
      nrm_ff      <= nrm_in;
      shc_ff      <= shc_in;
      lvl_ff      <= lvl_in;
      kn_ff       <= kn_in;
      neg_ff      <= neg_in;
      tf_ff       <= tf_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      g_ff        <= g_in;
      e_ff        <= e_in;
      s_ff        <= s_in;
      o_sample_ff <= o_sample_in;
      o_gain_ff   <= o_gain_in;
      o_last_ff   <= o_last_in;
      o_min_ff    <= o_min_in;
   end

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   a_trk_nonpos: assert property (@(posedge clock) disable iff (reset)
      trk_ff <= 16'sd0)
      else $error("frame minimum went positive");

   a_trk_clear: assert property (@(posedge clock) disable iff (reset)
      (out_load && fend_ff) |=> (trk_ff == 16'sd0))
      else $error("frame minimum not cleared at frame end");

   a_min_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_last) |-> (rsp_frame_min_gain == 16'sd0))
      else $error("frame minimum reported off frame end");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_ENV))
      else $error("accepted word did not start the envelope update");

   a_div_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff <= 5'(QUO_W - 1)))
      else $error("divider step count out of range");

endmodule
